@@ src/lats_pkg.sv @@
// ----------------------------------------------------------------------------
// lats_pkg
// Shared widths, command codes and register indexes for the toroidal
// life automaton step block.
// ----------------------------------------------------------------------------
package lats_pkg;

	localparam int KIND_W     = 2;
	localparam int COL_W      = 6;
	localparam int ROW_W      = 6;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int SIZE_RESET = 64;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_WRITE   = 2'd0;
	localparam kind_t KIND_TOGGLE  = 2'd1;
	localparam kind_t KIND_READ    = 2'd2;
	localparam kind_t KIND_ADVANCE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

endpackage

@@ src/life_automaton_toroidal_step.sv @@
// ----------------------------------------------------------------------------
// life_automaton_toroidal_step
// B3/S23 cell grid on a torus: cell write, toggle, read, and a row-serial
// generation step over a row memory with a three-row window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+---------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | kind, col, row, cell_value
//  out     | out       | out_valid/out_stall| alive, out_of_range
//
//  A cell access is one registered row read, then a row write-back for an in-range write or toggle.
//  A generation step walks the rows in order; the grid memory has one row
//  read port and one row write port, and each row is written back once.
//  One beat is in flight at a time; in_stall stays high until its result is
//  taken on the out channel, so out_stall holds the whole block.
//  Reset clears one valid bit per row; an invalid row reads as all dead.
// ----------------------------------------------------------------------------
module life_automaton_toroidal_step
	import lats_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  kind_t                 kind,
	input  logic [COL_W-1:0]      col,
	input  logic [ROW_W-1:0]      row,
	input  logic                  cell_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  alive,
	output logic                  out_of_range
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int AW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WSZ = $clog2(MAX_WIDTH + 1);
	localparam int HSZ = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : SIZE_RESET;
	localparam int H_RST = (SIZE_RESET > MAX_HEIGHT) ? MAX_HEIGHT : SIZE_RESET;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CELL = 3'd1;
	localparam logic [2:0] ST_GUP  = 3'd2;
	localparam logic [2:0] ST_GMID = 3'd3;
	localparam logic [2:0] ST_GRD  = 3'd4;
	localparam logic [2:0] ST_GROW = 3'd5;

	logic [2:0]            state_q;
	logic [WSZ-1:0]        w_q;
	logic [HSZ-1:0]        h_q;
	logic [AW-1:0]         y_q;
	logic [MAX_HEIGHT-1:0] vld_q;
	logic                  out_valid_q;
	logic                  alive_q;
	logic                  oor_out_q;

	logic [MAX_WIDTH-1:0]  mem [MAX_HEIGHT];
	logic [MAX_WIDTH-1:0]  rd_data_q;
	logic                  rd_vld_q;
	logic [MAX_WIDTH-1:0]  up_q;
	logic [MAX_WIDTH-1:0]  mid_q;
	logic [MAX_WIDTH-1:0]  first_q;
	kind_t                 kind_q;
	logic [CW-1:0]         col_q;
	logic [AW-1:0]         row_q;
	logic                  val_q;
	logic                  oor_q;

	logic                  accept;
	logic                  oor_in;
	logic [AW-1:0]         rd_addr;
	logic [MAX_WIDTH-1:0]  rd_row;
	logic [MAX_WIDTH-1:0]  dn_row;
	logic [MAX_WIDTH-1:0]  next_row;
	logic [MAX_WIDTH-1:0]  cell_row;
	logic                  old_bit;
	logic                  new_bit;
	logic                  cell_wr;
	logic                  last_row;
	logic                  w1;
	logic                  h1;
	logic                  hw1;
	logic [CW-1:0]         wlast;

	function automatic int clamp_size(input logic [CFG_DATA_W-1:0] v, input int maxv);
		int r;
		r = int'(v);
		if (r < 1) r = 1;
		if (r > maxv) r = maxv;
		return r;
	endfunction

	assign in_stall     = (state_q != ST_IDLE) || out_valid_q;
	assign accept       = in_valid && !in_stall;
	assign out_valid    = out_valid_q;
	assign alive        = alive_q;
	assign out_of_range = oor_out_q;

	assign oor_in   = (32'(col) >= 32'(w_q)) || (32'(row) >= 32'(h_q));
	assign rd_row   = rd_vld_q ? rd_data_q : '0;
	assign last_row = (32'(y_q) == 32'(h_q) - 32'd1);
	assign dn_row   = last_row ? first_q : rd_row;
	assign w1       = (32'(w_q) == 32'd1);
	assign h1       = (32'(h_q) == 32'd1);
	assign hw1      = w1 && h1;
	assign wlast    = CW'(32'(w_q) - 32'd1);

	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				if (kind == KIND_ADVANCE) begin
					rd_addr = AW'(32'(h_q) - 32'd1);
				end else begin
					rd_addr = AW'(32'(row));
				end
			end
			ST_GUP:  rd_addr = '0;
			ST_GRD:  rd_addr = AW'(32'(y_q) + 32'd1);
			default: rd_addr = row_q;
		endcase
	end

	assign old_bit = rd_row[col_q];

	always_comb begin
		new_bit = old_bit;
		cell_wr = 1'b0;
		unique case (kind_q)
			KIND_WRITE: begin
				new_bit = val_q;
				cell_wr = !oor_q;
			end
			KIND_TOGGLE: begin
				new_bit = ~old_bit;
				cell_wr = !oor_q;
			end
			KIND_READ:    new_bit = old_bit;
			KIND_ADVANCE: new_bit = 1'b0;
			default:      new_bit = old_bit;
		endcase
		cell_row        = rd_row;
		cell_row[col_q] = new_bit;
	end

	for (genvar gx = 0; gx < MAX_WIDTH; gx++) begin : g_lane
		localparam int XL = (gx == 0) ? 0 : gx - 1;
		localparam int XR = (gx == MAX_WIDTH - 1) ? 0 : gx + 1;
		logic       upl, upr, mdl, mdr, dnl, dnr;
		logic       at_wrap;
		logic [3:0] cnt;

		assign at_wrap = (wlast == CW'(gx));
		assign upl = (gx == 0) ? up_q[wlast]   : up_q[XL];
		assign mdl = (gx == 0) ? mid_q[wlast]  : mid_q[XL];
		assign dnl = (gx == 0) ? dn_row[wlast] : dn_row[XL];
		assign upr = at_wrap ? up_q[0]   : up_q[XR];
		assign mdr = at_wrap ? mid_q[0]  : mid_q[XR];
		assign dnr = at_wrap ? dn_row[0] : dn_row[XR];

		assign cnt = 4'(upl & ~hw1) + 4'(up_q[gx] & ~h1) + 4'(upr & ~hw1)
			+ 4'(mdl & ~w1) + 4'(mdr & ~w1)
			+ 4'(dnl & ~hw1) + 4'(dn_row[gx] & ~h1) + 4'(dnr & ~hw1);

		assign next_row[gx] = (32'(w_q) > gx)
			&& ((cnt == 4'd3) || (mid_q[gx] && (cnt == 4'd2)));
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
		if (state_q == ST_CELL && cell_wr) begin
			mem[row_q] <= cell_row;
		end
		if (state_q == ST_GROW) begin
			mem[y_q] <= next_row;
			up_q     <= mid_q;
			mid_q    <= dn_row;
		end
		if (state_q == ST_GUP) begin
			up_q <= rd_row;
		end
		if (state_q == ST_GMID) begin
			mid_q   <= rd_row;
			first_q <= rd_row;
		end
		if (accept) begin
			kind_q <= kind;
			col_q  <= CW'(32'(col));
			row_q  <= AW'(32'(row));
			val_q  <= cell_value;
			oor_q  <= oor_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			w_q         <= WSZ'(W_RST);
			h_q         <= HSZ'(H_RST);
			y_q         <= '0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			alive_q     <= 1'b0;
			oor_out_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  w_q <= WSZ'(clamp_size(cfg_data, MAX_WIDTH));
					CFG_HEIGHT: h_q <= HSZ'(clamp_size(cfg_data, MAX_HEIGHT));
					default:    w_q <= w_q;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						y_q     <= '0;
						state_q <= (kind == KIND_ADVANCE) ? ST_GUP : ST_CELL;
					end
				end
				ST_CELL: begin
					if (cell_wr) begin
						vld_q[row_q] <= 1'b1;
					end
					out_valid_q <= 1'b1;
					alive_q     <= oor_q ? 1'b0 : new_bit;
					oor_out_q   <= oor_q;
					state_q     <= ST_IDLE;
				end
				ST_GUP:  state_q <= ST_GMID;
				ST_GMID: state_q <= ST_GRD;
				ST_GRD:  state_q <= ST_GROW;
				ST_GROW: begin
					vld_q[y_q] <= 1'b1;
					if (last_row) begin
						for (int i = 0; i < MAX_HEIGHT; i++) begin
							if (i >= int'(h_q)) begin
								vld_q[i] <= 1'b0;
							end
						end
						out_valid_q <= 1'b1;
						alive_q     <= 1'b0;
						oor_out_q   <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						y_q     <= y_q + AW'(1);
						state_q <= ST_GRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
